FILE: rtl/sfr_pkg.sv
// shared types and constants of the streaming find-and-replace block
package sfr_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_W      = 4;
   localparam int BYTE_IDX_W = 3;

   localparam int MAX_REPLACEMENT_BYTES = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   // source of an emitted byte
   localparam logic [1:0] SEL_HELD  = 2'd0;
   localparam logic [1:0] SEL_REPL  = 2'd1;
   localparam logic [1:0] SEL_INPUT = 2'd2;
   localparam logic [1:0] SEL_NULL  = 2'd3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       text_end;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       emit;
      logic [1:0] sel;
      logic       run_last;
      logic       shift;
      logic       clear;
      logic       repl_inc;
      logic       repl_clr;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic plen_zero;
      logic full_match;
      logic is_prefix;
      logic count_zero;
      logic count_one;
      logic shifted_prefix;
      logic repl_last;
      logic rlen_zero;
      logic last;
   } status_type;

endpackage

FILE: rtl/sfr_dp.sv
// datapath: config registers, held byte buffer, pattern compare and result register
module sfr_dp #(
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sfr_pkg::req_type                 req_data,
   input  logic                             csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  sfr_pkg::cmd_type                 cmd,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output sfr_pkg::rsp_type                 rsp_data,
   output sfr_pkg::status_type              status
);

   localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int LEN_W = sfr_pkg::LEN_W;
   localparam int IDX_W = sfr_pkg::BYTE_IDX_W;

   logic [sfr_pkg::CSR_DATA_W-1:0] pat_bytes_ff, pat_bytes_in;
   logic [LEN_W-1:0]               pat_len_ff, pat_len_in;
   logic [sfr_pkg::CSR_DATA_W-1:0] rep_bytes_ff, rep_bytes_in;
   logic [LEN_W-1:0]               rep_len_ff, rep_len_in;

   logic [7:0]       held_ff [MAX_PATTERN_BYTES];
   logic [7:0]       held_in [MAX_PATTERN_BYTES];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             last_ff, last_in;
   logic [sfr_pkg::BYTE_IDX_W-1:0] repl_idx_ff, repl_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sfr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0] plen;
   logic [LEN_W-1:0] rlen;
   logic [CNT_W-1:0] base;
   logic             prefix_ok, shifted_ok;
   logic [7:0]       repl_byte;

   // lengths above the supported maximum count as the maximum
   assign plen = (pat_len_ff > LEN_W'(MAX_PATTERN_BYTES)) ? CNT_W'(MAX_PATTERN_BYTES)
                                                          : pat_len_ff[CNT_W-1:0];
   assign rlen = (rep_len_ff > LEN_W'(sfr_pkg::MAX_REPLACEMENT_BYTES))
                 ? LEN_W'(sfr_pkg::MAX_REPLACEMENT_BYTES) : rep_len_ff;

   assign base = (count_ff >= plen) ? '0 : count_ff;
   assign repl_byte = rep_bytes_ff[{repl_idx_ff, 3'b000} +: 8];

   // held bytes against the pattern, and held bytes one place on against it
   always_comb begin
      prefix_ok  = (count_ff <= plen);
      shifted_ok = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if ((CNT_W'(i) < count_ff) && (held_ff[i] != pat_bytes_ff[8*i +: 8])) begin
            prefix_ok = 1'b0;
         end
      end
      for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
         if ((CNT_W'(i + 1) < count_ff) && (held_ff[i+1] != pat_bytes_ff[8*i +: 8])) begin
            shifted_ok = 1'b0;
         end
      end
   end

   always_comb begin
      status.out_free       = !rsp_valid_ff || rsp_ready;
      status.plen_zero      = (plen == '0);
      status.is_prefix      = prefix_ok;
      status.full_match     = prefix_ok && (count_ff == plen);
      status.count_zero     = (count_ff == '0);
      status.count_one      = (count_ff == CNT_W'(1));
      status.shifted_prefix = shifted_ok;
      status.repl_last      = ((LEN_W'(repl_idx_ff) + LEN_W'(1)) == rlen);
      status.rlen_zero      = (rlen == '0);
      status.last           = last_ff;
   end

   always_comb begin
      pat_bytes_in = pat_bytes_ff;
      pat_len_in   = pat_len_ff;
      rep_bytes_in = rep_bytes_ff;
      rep_len_in   = rep_len_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      in_byte_in   = in_byte_ff;
      last_in      = last_ff;
      repl_idx_in  = repl_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.accept) begin
         in_byte_in = req_data.text_byte;
         last_in    = req_data.text_last;
         if (plen == '0) begin
            count_in = '0;
         end else begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
               if (base == CNT_W'(i)) begin
                  held_in[i] = req_data.text_byte;
               end
            end
            count_in = base + CNT_W'(1);
         end
      end

      if (cmd.shift) begin
         for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
            held_in[i] = held_ff[i+1];
         end
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.clear) begin
         count_in = '0;
      end

      if (cmd.repl_clr) begin
         repl_idx_in = '0;
      end else if (cmd.repl_inc) begin
         repl_idx_in = repl_idx_ff + IDX_W'(1);
      end

      // result register: loads a new beat or empties once taken
      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.run_last = cmd.run_last;
         rsp_data_in.text_end = cmd.run_last && last_ff;
         rsp_data_in.byte_valid = 1'b1;
         case (cmd.sel)
            sfr_pkg::SEL_HELD:  rsp_data_in.out_byte = held_ff[0];
            sfr_pkg::SEL_REPL:  rsp_data_in.out_byte = repl_byte;
            sfr_pkg::SEL_INPUT: rsp_data_in.out_byte = in_byte_ff;
            sfr_pkg::SEL_NULL: begin
               rsp_data_in.out_byte   = 8'd0;
               rsp_data_in.byte_valid = 1'b0;
            end
            default: rsp_data_in.out_byte = 8'd0;
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            sfr_pkg::CSR_PATTERN_BYTES: begin
               pat_bytes_in = csr_wdata;
               count_in     = '0;
            end
            sfr_pkg::CSR_PATTERN_LENGTH: begin
               pat_len_in = csr_wdata[LEN_W-1:0];
               count_in   = '0;
            end
            sfr_pkg::CSR_REPLACEMENT_BYTES:  rep_bytes_in = csr_wdata;
            sfr_pkg::CSR_REPLACEMENT_LENGTH: rep_len_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= '0;
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_bytes_ff <= pat_bytes_in;
         pat_len_ff   <= pat_len_in;
         rep_bytes_ff <= rep_bytes_in;
         rep_len_ff   <= rep_len_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      in_byte_ff  <= in_byte_in;
      last_ff     <= last_in;
      repl_idx_ff <= repl_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/sfr_ctrl.sv
// controller: sequences accept, compare, replacement and flush per input beat
module sfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sfr_pkg::status_type status,
   output sfr_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_REPL  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       emitted_ff, emitted_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = sfr_pkg::SEL_HELD;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (status.out_free) begin
               if (status.plen_zero) begin
                  cmd.emit     = 1'b1;
                  cmd.sel      = sfr_pkg::SEL_INPUT;
                  cmd.run_last = 1'b1;
                  state_in     = ST_IDLE;
               end else if (status.full_match) begin
                  cmd.clear    = 1'b1;
                  cmd.repl_clr = 1'b1;
                  if (!status.rlen_zero) begin
                     state_in = ST_REPL;
                  end else begin
                     // empty replacement on the final beat leaves an end marker
                     if (status.last) begin
                        cmd.emit     = 1'b1;
                        cmd.sel      = sfr_pkg::SEL_NULL;
                        cmd.run_last = 1'b1;
                     end
                     state_in = ST_IDLE;
                  end
               end else if (!status.count_zero && !status.is_prefix) begin
                  // oldest byte can no longer start a match
                  cmd.emit     = 1'b1;
                  cmd.sel      = sfr_pkg::SEL_HELD;
                  cmd.shift    = 1'b1;
                  cmd.run_last = status.count_one ||
                                 (status.shifted_prefix && !status.last);
               end else if (status.last) begin
                  if (status.count_zero) begin
                     if (!emitted_ff) begin
                        cmd.emit     = 1'b1;
                        cmd.sel      = sfr_pkg::SEL_NULL;
                        cmd.run_last = 1'b1;
                     end
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_REPL: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = sfr_pkg::SEL_REPL;
               cmd.run_last = status.repl_last;
               cmd.repl_inc = !status.repl_last;
               if (status.repl_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = sfr_pkg::SEL_HELD;
               cmd.shift    = 1'b1;
               cmd.run_last = status.count_one;
               if (status.count_one) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      emitted_in = emitted_ff;
      if (cmd.accept) begin
         emitted_in = 1'b0;
      end else if (cmd.emit) begin
         emitted_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         emitted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule

FILE: rtl/stream_find_replace.sv
// top level of the streaming find-and-replace block
// usage:
// - req channel takes one text byte per beat with text_last on the final byte of a text
// - rsp channel gives the edited text one byte per beat; run_last marks the last beat
//   caused by an input byte, text_end the last beat of the whole text; a final input
//   that yields no byte gives one beat with byte_valid low
// - csr port writes pattern, pattern length, replacement and replacement length;
//   write only while idle; a pattern or pattern length write drops held bytes
// timing:
// - an input byte is taken in the idle state, then the evaluate state decides what it releases
// - a pass-through byte, an empty end marker and each released byte go out from the evaluate
//   state itself; an item that releases nothing returns straight to idle
// - replacement bytes go out from the replace state and flushed bytes from the flush state;
//   every state that emits waits while the result register is full and rsp_ready is low
// - the result register sits between the sides: a finished beat may wait on rsp_ready
//   while the next byte is taken
// - the first result is loaded in the evaluate state, or in the replace or flush state that
//   follows it when it comes from the replacement or an end-of-text flush
// reset clears config, held byte count, controller state and the result register
// when the receiver stalls the controller holds in its state until the result
// register frees up; no beat is dropped
module stream_find_replace #(
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sfr_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sfr_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sfr_pkg::cmd_type    cmd;
   sfr_pkg::status_type status;

   // sequencer
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // held bytes, compare and result register
   sfr_dp #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // end of text is always the closing beat of its input
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.text_end) |-> rsp_data.run_last)
      else $error("text_end without run_last");

   // the empty marker only closes a text
   a_null_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.byte_valid) |-> rsp_data.text_end)
      else $error("empty beat before end of text");

   // no beat is produced in the cycle a byte is taken
   a_no_emit_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !cmd.emit)
      else $error("emit during accept");

   // an accepted byte is always evaluated before the next one
   a_eval_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("back to back accept");

   // a beat is only loaded when the result register can take it
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result register overrun");

endmodule

FILE: verif/tb.sv
// self-checking testbench for the streaming find-and-replace block
`timescale 1ns / 100ps

module tb;

   localparam int MAX_PAT       = 8;
   localparam int MAX_REP       = sfr_pkg::MAX_REPLACEMENT_BYTES;
   localparam int SETTLE_CYCLES = 8;    // no-result beats may still be in flight
   localparam int TAIL_CYCLES   = 20;
   localparam int REPORT_LIMIT  = 10;
   localparam int HOLD_CYCLES   = 200;

   logic                           clock;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   sfr_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   sfr_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index = sfr_pkg::CSR_PATTERN_BYTES;
   logic [sfr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // mirror of the block's registers and held bytes, reset values included
   logic [63:0] pat_word = '0;
   logic [3:0]  pat_len  = '0;
   logic [63:0] rep_word = '0;
   logic [3:0]  rep_len  = '0;
   logic [7:0]  held_text [MAX_PAT];
   int          held_n   = 0;

   // edited text still owed by the block, oldest beat first
   sfr_pkg::rsp_type edit_q[$];

   int fail_count    = 0;
   int bytes_sent    = 0;
   int beats_checked = 0;
   int settings_used = 0;
   int replaced_runs = 0;
   int null_marks    = 0;

   // sender bursts and receiver stalls
   int gaps_on      = 1;
   int burst_left   = 0;
   int stall_pct    = 0;
   int hold_request = 0;

   stream_find_replace #(
      .MAX_PATTERN_BYTES(MAX_PAT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------
   // edit predictor
   // ---------------------------------------------------------------

   // lengths above the maximum count as the maximum
   function automatic int cap_len(logic [3:0] len, int cap);
      return (len > cap) ? cap : int'(len);
   endfunction

   function automatic logic [7:0] byte_at(logic [63:0] word, int i);
      return word[8*i +: 8];
   endfunction

   // held bytes still form a start of the pattern, at most its full length
   function automatic bit held_is_pattern_prefix(int pe);
      if (held_n > pe) return 1'b0;
      for (int i = 0; i < held_n; i++)
         if (held_text[i] != byte_at(pat_word, i)) return 1'b0;
      return 1'b1;
   endfunction

   // work out the beats one text byte releases and queue them
   task automatic predict_edit(input sfr_pkg::req_type item);
      int               pe;
      int               re;
      sfr_pkg::rsp_type run[$];
      sfr_pkg::rsp_type beat;
      pe = cap_len(pat_len, MAX_PAT);
      re = cap_len(rep_len, MAX_REP);
      beat = '0;
      beat.byte_valid = 1'b1;
      if (pe == 0) begin
         // no pattern: straight pass-through
         held_n = 0;
         beat.out_byte = item.text_byte;
         run.push_back(beat);
      end else begin
         if (held_n >= pe) held_n = 0;
         held_text[held_n] = item.text_byte;
         held_n++;
         if (held_n == pe && held_is_pattern_prefix(pe)) begin
            // whole pattern seen: swap in the replacement, never rescanned
            for (int i = 0; i < re; i++) begin
               beat.out_byte = byte_at(rep_word, i);
               run.push_back(beat);
            end
            held_n = 0;
            replaced_runs++;
         end else begin
            // release the oldest byte until the rest is a prefix again
            while (held_n > 0 && !held_is_pattern_prefix(pe)) begin
               beat.out_byte = held_text[0];
               run.push_back(beat);
               for (int i = 1; i < held_n; i++) held_text[i-1] = held_text[i];
               held_n--;
            end
         end
         if (item.text_last) begin
            // end of text flushes whatever is held
            for (int i = 0; i < held_n; i++) begin
               beat.out_byte = held_text[i];
               run.push_back(beat);
            end
            held_n = 0;
         end
      end
      if (item.text_last && run.size() == 0) begin
         // empty end marker
         beat = '0;
         run.push_back(beat);
         null_marks++;
      end
      if (run.size() > 0) begin
         run[run.size()-1].run_last = 1'b1;
         run[run.size()-1].text_end = item.text_last;
      end
      foreach (run[k]) edit_q.push_back(run[k]);
   endtask

   // ---------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, msg);
   endfunction

   always @(posedge clock) begin
      sfr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (edit_q.size() == 0) begin
            note_failure($sformatf("beat with nothing owed: byte %h valid %b run_last %b end %b",
               rsp_data.out_byte, rsp_data.byte_valid, rsp_data.run_last, rsp_data.text_end));
         end else begin
            want = edit_q.pop_front();
            beats_checked++;
            if (rsp_data.out_byte !== want.out_byte || rsp_data.byte_valid !== want.byte_valid ||
                rsp_data.run_last !== want.run_last || rsp_data.text_end !== want.text_end)
               note_failure($sformatf(
                  "expected byte %h valid %b run_last %b end %b, got %h %b %b %b",
                  want.out_byte, want.byte_valid, want.run_last, want.text_end,
                  rsp_data.out_byte, rsp_data.byte_valid, rsp_data.run_last,
                  rsp_data.text_end));
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: random stall phases, plus a long hold-off on request
   // ---------------------------------------------------------------

   initial begin : rsp_side
      int hold_left;
      int phase_left;
      hold_left  = 0;
      phase_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (phase_left == 0) begin
            case ($urandom_range(2))
               0: stall_pct = 0;
               1: stall_pct = 25;
               default: stall_pct = 60;
            endcase
            phase_left = $urandom_range(80, 20);
         end
         phase_left--;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // offer one text byte, holding it until taken; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      sfr_pkg::req_type item;
      if (gaps_on != 0 && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
         burst_left = $urandom_range(16, 1);
      end
      if (burst_left > 0) burst_left--;
      item.text_byte = b;
      item.text_last = last;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_edit(item);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] txt[$]);
      foreach (txt[k]) send_byte(txt[k], k == txt.size() - 1);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // wait until every owed beat is out, then let in-flight bytes finish
   task automatic settle();
      req_valid <= 1'b0;
      while (edit_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [sfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         sfr_pkg::CSR_PATTERN_BYTES: begin
            pat_word = data;
            held_n   = 0;
         end
         sfr_pkg::CSR_PATTERN_LENGTH: begin
            pat_len = data[3:0];
            held_n  = 0;
         end
         sfr_pkg::CSR_REPLACEMENT_BYTES:  rep_word = data;
         sfr_pkg::CSR_REPLACEMENT_LENGTH: rep_len  = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [63:0] pw, input logic [63:0] plw,
                            input logic [63:0] rw, input logic [63:0] rlw);
      settle();
      csr_write(sfr_pkg::CSR_PATTERN_BYTES, pw);
      csr_write(sfr_pkg::CSR_PATTERN_LENGTH, plw);
      csr_write(sfr_pkg::CSR_REPLACEMENT_BYTES, rw);
      csr_write(sfr_pkg::CSR_REPLACEMENT_LENGTH, rlw);
      settings_used++;
   endtask

   // text made mostly of pattern pieces so matches, near misses and re-checks happen
   task automatic build_text(output logic [7:0] txt[$], input int len);
      int pe;
      int r;
      int n;
      pe = cap_len(pat_len, MAX_PAT);
      txt.delete();
      while (txt.size() < len) begin
         r = $urandom_range(9);
         if (pe == 0 || r == 9) begin
            txt.push_back(8'($urandom_range(255)));
         end else if (r <= 4) begin
            for (int k = 0; k < pe; k++) txt.push_back(byte_at(pat_word, k));
         end else if (r <= 6) begin
            n = $urandom_range(pe, 1);
            for (int k = 0; k < n; k++) txt.push_back(byte_at(pat_word, k));
         end else if (r == 7) begin
            txt.push_back(byte_at(pat_word, $urandom_range(pe - 1)));
         end else begin
            // near miss: one bit off a pattern byte
            txt.push_back(byte_at(pat_word, $urandom_range(pe - 1)) ^
                          (8'h01 << $urandom_range(7)));
         end
      end
      while (txt.size() > len) void'(txt.pop_back());
   endtask

   task automatic random_setting();
      logic [63:0] pw;
      logic [63:0] plw;
      logic [63:0] rw;
      logic [63:0] rlw;
      // mostly a small alphabet, so repeated bytes make overlapping near matches
      if ($urandom_range(9) < 7) begin
         for (int i = 0; i < 8; i++) pw[8*i +: 8] = 8'h61 + 8'($urandom_range(2));
      end else begin
         pw = {$urandom, $urandom};
      end
      rw  = {$urandom, $urandom};
      plw = {$urandom, $urandom};
      rlw = {$urandom, $urandom};
      // upper bits of the length registers are don't-care; usually keep them clear
      if ($urandom_range(3) != 0) plw[63:4] = '0;
      if ($urandom_range(3) != 0) rlw[63:4] = '0;
      case ($urandom_range(9))
         0:       plw[3:0] = 4'd0;
         1:       plw[3:0] = 4'd8;
         2:       plw[3:0] = 4'($urandom_range(15, 9));
         default: plw[3:0] = 4'($urandom_range(7, 1));
      endcase
      rlw[3:0] = 4'($urandom_range(15));
      configure(pw, plw, rw, rlw);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset config has an empty pattern: bytes go straight through
   task automatic test_pass_through();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
   endtask

   // pattern "abc" -> "XY": false start, match, then a held prefix flushed at the end
   task automatic test_match_and_flush();
      configure(64'h0000_0000_0063_6261, 64'd3, 64'h0000_0000_0000_5958, 64'd2);
      send_string("aabcab");
   endtask

   // empty replacement: last byte releases nothing, so an end marker comes out
   task automatic test_empty_replacement();
      configure(64'h0000_0000_0000_6261, 64'd2, 64'h0, 64'd0);
      send_string("ab");
   endtask

   // full-width pattern and replacement, oversized lengths clamp to eight
   task automatic test_length_extremes();
      configure('1, 64'd15, '0, 64'd15);
      for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 7);
      configure('0, 64'd1, '1, 64'd8);
      send_byte(8'h00, 1'b1);
   endtask

   // rewriting the pattern or its length mid-text drops held bytes
   task automatic test_pattern_rewrite();
      configure(64'h0000_0000_0063_6261, 64'd3, 64'h0000_0000_0000_0021, 64'd1);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      settle();
      csr_write(sfr_pkg::CSR_PATTERN_BYTES, 64'h0000_0000_007A_7978);
      send_string("cxyz");
      send_byte(8'h78, 1'b0);
      settle();
      csr_write(sfr_pkg::CSR_PATTERN_LENGTH, 64'd2);
      send_string("xy");
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_receiver_hold_off();
      logic [7:0] txt[$];
      configure(64'h0000_0000_0000_6261, 64'd2, {$urandom, $urandom}, 64'd8);
      gaps_on = 0;
      for (int i = 0; i < 30; i++) begin
         if ($urandom_range(9) < 8) txt.push_back((i % 2 == 0) ? 8'h61 : 8'h62);
         else txt.push_back(8'($urandom_range(255)));
      end
      hold_request = HOLD_CYCLES;
      send_text(txt);
      gaps_on = 1;
   endtask

   // random settings, each followed by a handful of texts
   task automatic test_random_texts(input int count);
      int stop_at;
      int phase_items;
      int len;
      logic [7:0] txt[$];
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         random_setting();
         gaps_on = ($urandom_range(3) != 0);
         phase_items = 0;
         while (phase_items < 20 && bytes_sent < stop_at) begin
            len = $urandom_range(14, 1);
            build_text(txt, len);
            send_text(txt);
            phase_items += len;
         end
      end
      gaps_on = 1;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      // synchronous reset, held and then released at a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_pass_through();
      test_match_and_flush();
      test_empty_replacement();
      test_length_extremes();
      test_pattern_rewrite();
      test_receiver_hold_off();
      test_random_texts(215);

      // drain whatever is still owed, then watch for stray beats
      req_valid <= 1'b0;
      while (edit_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d text bytes under %0d register settings, %0d beats checked",
         bytes_sent, settings_used, beats_checked);
      $display("%0d pattern hits, %0d empty end markers, one %0d-cycle receiver hold-off",
         replaced_runs, null_marks, HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
